FILE: design/sos_pkg.sv
// Package for the seed overlap scan block: the input, result and table entry
// item types, the scan state type, and the default table depth.
// No dependencies; every design file imports it.
package sos_pkg;

  // Fixed field widths of the item formats
  localparam int QBEG_W  = 16;
  localparam int RBEG_W  = 40;
  localparam int LEN_W   = 16;
  localparam int EPOS_W  = 6;
  localparam int POS_W   = 7;

  // Default number of table entries
  localparam int TABLE_DEPTH_DEF = 64;

  // Item kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [EPOS_W-1:0] entry_position;
    logic              removed_flag;
    logic [QBEG_W-1:0] seed_qbeg;
    logic [RBEG_W-1:0] seed_rbeg;
    logic [LEN_W-1:0]  seed_len;
    logic [POS_W-1:0]  start_position;
    logic [POS_W-1:0]  chain_length;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] hit_position;
    logic             found;
  } out_item_t;

  // One stored table entry
  typedef struct packed {
    logic              removed;
    logic [LEN_W-1:0]  len;
    logic [RBEG_W-1:0] rbeg;
    logic [QBEG_W-1:0] qbeg;
  } entry_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

endpackage

FILE: design/seed_overlap_scan.sv
// Seed overlap scan top level: seed table memory, scan sequencer and
// overlap test over one registered table entry a cycle.
// Depends on sos_pkg.
//
// Usage:
// - Input channel: an item is taken at a clock edge where start is high and
//   busy is low. kind selects a load (write one table entry at
//   entry_position, ignored when that is at or beyond TABLE_DEPTH) or a
//   query (scan from start_position below chain_length).
// - A load gives no result and leaves busy low; the next item may follow in
//   the next cycle.
// - A query raises busy and walks the table one entry per cycle: each entry
//   is read into a register and checked in the cycle after. The first
//   qualifying entry ends the scan with a hit at its position; with none, the
//   scan ends with a miss that reports the larger of start_position and chain_length.
// - The result is on out_item for exactly one cycle, marked by out_strobe;
//   the receiver cannot hold it off. busy falls in that cycle, so a new item
//   may be taken while the result is shown.
// - Reset clears the sequencer and the strobe, not the table.
module seed_overlap_scan
  import sos_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Table memory, one packed entry per position
  entry_t mem [TABLE_DEPTH];

  state_t           state_r, state_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] end_r, end_nxt;
  logic [POS_W-1:0] miss_pos_r, miss_pos_nxt;
  logic [POS_W-1:0] chk_pos_r, chk_pos_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [QBEG_W-1:0] sq_r, sq_nxt;
  logic [RBEG_W-1:0] sr_r, sr_nxt;
  logic [LEN_W-1:0]  sl_r, sl_nxt;
  logic             out_strobe_r, out_strobe_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             accept;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [AW-1:0]    rd_addr;
  entry_t           rd_data_r;
  entry_t           wr_data;
  logic             issue;
  logic             qualifies;

  // Overlap test terms
  logic [20:0]        tl_x20;
  logic [20:0]        sl_x19;
  logic signed [17:0] ov_a;
  logic signed [17:0] ov_b;
  logic signed [17:0] need;
  logic signed [40:0] dq;
  logic signed [40:0] dr;
  logic               diag_diff;
  logic               case_a;
  logic               case_b;

  assign accept  = start && (state_r == ST_IDLE);
  assign busy    = (state_r != ST_IDLE);
  assign wr_en   = accept && (in_item.kind == KIND_LOAD) &&
                   (int'(in_item.entry_position) < TABLE_DEPTH);
  assign wr_addr = AW'(in_item.entry_position);
  assign wr_data = '{removed: in_item.removed_flag, len: in_item.seed_len,
                     rbeg: in_item.seed_rbeg, qbeg: in_item.seed_qbeg};
  assign rd_addr = AW'(pos_r);
  assign issue   = (state_r == ST_SCAN) && (pos_r < end_r);
  assign rd_en   = issue;

  // Write and read the table; loads and scans never share a cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Test the entry read in the previous cycle against the held seed
  always_comb begin
    tl_x20    = 21'(rd_data_r.len) * 21'd20;
    sl_x19    = 21'(sl_r) * 21'd19;
    need      = $signed({4'b0, sl_r[LEN_W-1:2]});
    ov_a      = $signed({2'b0, sq_r}) + $signed({2'b0, sl_r}) -
                $signed({2'b0, rd_data_r.qbeg});
    ov_b      = $signed({2'b0, rd_data_r.qbeg}) + $signed({2'b0, rd_data_r.len}) -
                $signed({2'b0, sq_r});
    dq        = $signed({25'b0, rd_data_r.qbeg}) - $signed({25'b0, sq_r});
    dr        = $signed({1'b0, rd_data_r.rbeg}) - $signed({1'b0, sr_r});
    diag_diff = (dq != dr);
    case_a    = (sq_r <= rd_data_r.qbeg) && (ov_a >= need);
    case_b    = (rd_data_r.qbeg <= sq_r) && (ov_b >= need);
    qualifies = !rd_data_r.removed && (tl_x20 >= sl_x19) && diag_diff &&
                (case_a || case_b);
  end

  // Sequence the scan and form the result
  always_comb begin
    state_nxt      = state_r;
    pos_nxt        = pos_r;
    end_nxt        = end_r;
    miss_pos_nxt   = miss_pos_r;
    chk_pos_nxt    = chk_pos_r;
    chk_vld_nxt    = chk_vld_r;
    sq_nxt         = sq_r;
    sr_nxt         = sr_r;
    sl_nxt         = sl_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    case (state_r)
      ST_IDLE: begin
        chk_vld_nxt = 1'b0;
        if (accept && (in_item.kind == KIND_QUERY)) begin
          state_nxt    = ST_SCAN;
          pos_nxt      = in_item.start_position;
          end_nxt      = (int'(in_item.chain_length) < TABLE_DEPTH) ?
                         in_item.chain_length : POS_W'(TABLE_DEPTH);
          miss_pos_nxt = (in_item.start_position > in_item.chain_length) ?
                         in_item.start_position : in_item.chain_length;
          sq_nxt       = in_item.seed_qbeg;
          sr_nxt       = in_item.seed_rbeg;
          sl_nxt       = in_item.seed_len;
        end
      end
      ST_SCAN: begin
        // advance the read pointer while entries remain
        chk_vld_nxt = issue;
        chk_pos_nxt = pos_r;
        if (issue) begin
          pos_nxt = pos_r + POS_W'(1);
        end
        if (chk_vld_r && qualifies) begin
          out_strobe_nxt            = 1'b1;
          out_item_nxt.hit_position = chk_pos_r;
          out_item_nxt.found        = 1'b1;
          chk_vld_nxt               = 1'b0;
          state_nxt                 = ST_IDLE;
        end else if (!issue && !chk_vld_r) begin
          out_strobe_nxt            = 1'b1;
          out_item_nxt.hit_position = miss_pos_r;
          out_item_nxt.found        = 1'b0;
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt   = ST_IDLE;
        chk_vld_nxt = 1'b0;
      end
    endcase
  end

  // Hold control state; clear it on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      chk_vld_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Hold scan payload
  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    end_r      <= end_nxt;
    miss_pos_r <= miss_pos_nxt;
    chk_pos_r  <= chk_pos_nxt;
    sq_r       <= sq_nxt;
    sr_r       <= sr_nxt;
    sl_r       <= sl_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

FILE: bench/tb.sv
`timescale 1ns / 100ps
// Testbench for seed_overlap_scan: a scoreboard keeps its own copy of the seed
// table, predicts the first overlapping entry of each query and checks every
// result. Depends on sos_pkg and the seed_overlap_scan RTL.
module tb;
  import sos_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 800;
  localparam int TAIL_CYCLES  = DEPTH + 16;
  localparam longint CYCLE_LIMIT = 600000;

  // Scoreboard: mirror of the seed table plus the queue of pending scan answers
  class overlap_scoreboard;
    entry_t    seed_tbl [DEPTH];
    out_item_t expected_hits [$];
    int        errors;

    function new();
      errors = 0;
      foreach (seed_tbl[i]) seed_tbl[i] = '0;
    endfunction

    // True when stored entry p overlaps the seed on another diagonal
    function bit entry_overlaps(int p, longint sq, longint sr, longint sl);
      longint tq, tr, tl, need;
      if (p >= DEPTH) return 1'b0;
      if (seed_tbl[p].removed) return 1'b0;
      tq = longint'(seed_tbl[p].qbeg);
      tr = longint'(seed_tbl[p].rbeg);
      tl = longint'(seed_tbl[p].len);
      // exact integer form of the 0.95 length ratio
      if (tl * 20 < sl * 19) return 1'b0;
      need = sl / 4;
      if (sq <= tq && sq + sl - tq >= need && (tq - sq) != (tr - sr)) return 1'b1;
      if (tq <= sq && tq + tl - sq >= need && (sq - tq) != (sr - tr)) return 1'b1;
      return 1'b0;
    endfunction

    // Walk the table from the start position and return the first hit
    function out_item_t first_overlap(in_item_t q);
      out_item_t res;
      longint    sq, sr, sl;
      sq = longint'(q.seed_qbeg);
      sr = longint'(q.seed_rbeg);
      sl = longint'(q.seed_len);
      res.found = 1'b0;
      res.hit_position = (q.start_position > q.chain_length) ? q.start_position
                                                             : q.chain_length;
      for (int p = int'(q.start_position); p < int'(q.chain_length); p++) begin
        if (entry_overlaps(p, sq, sr, sl)) begin
          res.hit_position = POS_W'(p);
          res.found = 1'b1;
          return res;
        end
      end
      return res;
    endfunction

    // Note one accepted item: loads update the table, queries queue an answer
    function void note_item(in_item_t it);
      if (it.kind == KIND_LOAD) begin
        if (int'(it.entry_position) < DEPTH) begin
          seed_tbl[it.entry_position].removed = it.removed_flag;
          seed_tbl[it.entry_position].qbeg    = it.seed_qbeg;
          seed_tbl[it.entry_position].rbeg    = it.seed_rbeg;
          seed_tbl[it.entry_position].len     = it.seed_len;
        end
      end else begin
        expected_hits = {expected_hits, first_overlap(it)};
      end
    endfunction

    // Compare one result with the oldest pending answer
    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_hits.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got hit_position=%0d found=%0d",
                 $time, got.hit_position, got.found);
        return;
      end
      want = expected_hits.pop_front();
      if (got.hit_position !== want.hit_position || got.found !== want.found) begin
        errors++;
        $display({"%0t: mismatch, expected hit_position=%0d found=%0d, ",
                  "got hit_position=%0d found=%0d"},
                 $time, want.hit_position, want.found, got.hit_position, got.found);
      end
    endfunction

    function int pending();
      return expected_hits.size();
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  overlap_scoreboard board;
  longint cycles = 0;
  int     burst_left;

  seed_overlap_scan #(.TABLE_DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_strobe) board.check_result(out_item);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("seed_overlap_scan regression: fail");
      $finish;
    end
  end

  function automatic in_item_t mk_load(int p, bit rem, int q, longint r, int l);
    in_item_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.entry_position = EPOS_W'(p);
    it.removed_flag = rem;
    it.seed_qbeg = QBEG_W'(q);
    it.seed_rbeg = RBEG_W'(r);
    it.seed_len = LEN_W'(l);
    return it;
  endfunction

  function automatic in_item_t mk_query(int q, longint r, int l, int s, int c);
    in_item_t it;
    it = '0;
    it.kind = KIND_QUERY;
    it.seed_qbeg = QBEG_W'(q);
    it.seed_rbeg = RBEG_W'(r);
    it.seed_len = LEN_W'(l);
    it.start_position = POS_W'(s);
    it.chain_length = POS_W'(c);
    return it;
  endfunction

  // Random load: mostly short seeds packed into a small window, some extremes
  function automatic in_item_t rand_load();
    in_item_t it;
    it.kind = KIND_LOAD;
    it.entry_position = EPOS_W'($urandom_range(0, DEPTH - 1));
    it.removed_flag = ($urandom_range(0, 3) == 0);
    it.seed_qbeg = ($urandom_range(0, 9) == 0) ? QBEG_W'($urandom)
                                               : QBEG_W'($urandom_range(0, 1023));
    it.seed_rbeg = ($urandom_range(0, 9) == 0) ? {8'($urandom), 32'($urandom)}
                                               : RBEG_W'($urandom_range(0, 20'hFFFFF));
    it.seed_len = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom)
                                              : LEN_W'($urandom_range(0, 255));
    it.start_position = POS_W'($urandom_range(0, DEPTH));
    it.chain_length = POS_W'($urandom_range(0, DEPTH));
    return it;
  endfunction

  // Random query: mostly short scan windows, seed mostly shaped after one entry in it
  function automatic in_item_t rand_query();
    in_item_t it;
    entry_t   e;
    int       lo, hi, p, sl, off, sq, diag;
    it = rand_load();
    it.kind = KIND_QUERY;
    case ($urandom_range(0, 9))
      0: begin
        lo = $urandom_range(0, DEPTH);
        hi = $urandom_range(0, lo);
      end
      1: begin
        lo = $urandom_range(0, 3);
        hi = DEPTH;
      end
      default: begin
        lo = $urandom_range(0, DEPTH - 1);
        hi = $urandom_range(lo + 1, (lo + 16 < DEPTH) ? lo + 16 : DEPTH);
      end
    endcase
    it.start_position = POS_W'(lo);
    it.chain_length = POS_W'(hi);
    if (hi > lo && $urandom_range(0, 3) != 0) begin
      p = $urandom_range(lo, hi - 1);
      e = board.seed_tbl[p];
      case ($urandom_range(0, 3))
        0: sl = (int'(e.len) * 20) / 19;
        1: sl = (int'(e.len) * 20) / 19 + 1;
        default: sl = $urandom_range(0, int'(e.len));
      endcase
      if (sl > 65535) sl = 65535;
      off = int'($urandom_range(0, sl + 2)) - (sl + 2) / 2;
      sq = int'(e.qbeg) + off;
      if (sq < 0) sq = 0;
      if (sq > 65535) sq = 65535;
      diag = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 16)) - 8;
      it.seed_len = LEN_W'(sl);
      it.seed_qbeg = QBEG_W'(sq);
      it.seed_rbeg = RBEG_W'(longint'(e.rbeg) + longint'(sq - int'(e.qbeg)) + longint'(diag));
    end
    return it;
  endfunction

  // Present one item and hold it until the block takes it and is no longer busy
  task automatic send_item(input in_item_t it);
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    board.note_item(it);
  endtask

  // Drop start with noise on the payload; n sets the idle length, zero for none
  task automatic idle(input int n);
    logic [95:0] noise;
    if (n > 0) begin
      noise = {$urandom, $urandom, $urandom};
      start <= 1'b0;
      in_item <= noise[$bits(in_item_t)-1:0];
      repeat (n) @(posedge clk);
    end
  endtask

  // Send in bursts of random length separated by random gaps
  task automatic paced_send(input in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end
    send_item(it);
    burst_left--;
  endtask

  // Hold off until every pending answer has come
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  initial begin
    board = new();
    burst_left = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Fill the whole table so that no scan reads an unwritten entry
    for (int p = 0; p < DEPTH; p++) begin
      in_item_t it;
      it = rand_load();
      it.entry_position = EPOS_W'(p);
      paced_send(it);
    end

    // Directed: ratio boundary, removed entry, field extremes, diagonals
    send_item(mk_load(0, 1'b0, 100, 1000, 19));
    send_item(mk_load(1, 1'b1, 100, 2000, 400));
    send_item(mk_load(2, 1'b0, 65535, 40'hFF_FFFF_FFFF, 65535));
    send_item(mk_load(3, 1'b0, 50, 500, 100));
    send_item(mk_load(DEPTH - 1, 1'b0, 0, 0, 0));
    send_item(mk_query(100, 1001, 20, 0, 1));
    send_item(mk_query(100, 1000, 20, 0, 1));
    send_item(mk_query(100, 1001, 21, 0, 1));
    send_item(mk_query(100, 5000, 400, 1, 2));
    send_item(mk_query(65535, 0, 65535, 2, 3));
    send_item(mk_query(0, 1, 0, DEPTH - 1, DEPTH));
    send_item(mk_query(0, 0, 0, DEPTH - 1, DEPTH));
    send_item(mk_query(120, 600, 40, 3, 4));
    send_item(mk_query(120, 570, 40, 3, 4));
    send_item(mk_query(160, 700, 40, 3, 4));
    send_item(mk_query(0, 0, 0, 0, 0));
    send_item(mk_query(7, 7, 7, DEPTH, DEPTH));
    send_item(mk_query(7, 7, 7, DEPTH, 0));
    send_item(mk_query(7, 7, 7, 10, 3));
    send_item(mk_query(65535, 40'hFF_FFFF_FFFF, 65535, 0, DEPTH));
    send_item(mk_query(0, 0, 1, 0, DEPTH));
    drain();

    // Random traffic, with one full drain halfway through
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain();
      paced_send(($urandom_range(0, 99) < 35) ? rand_load() : rand_query());
    end

    // Wait out the last answers, then watch for stray strobes
    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("seed_overlap_scan regression: pass");
    end else begin
      $display("seed_overlap_scan regression: fail");
    end
    $finish;
  end

endmodule
